@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define RWSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RWSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/rwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rwsp_pkg
// Widths, constants, control types and the microcode table of the replay
// wheel speed controller.
// ----------------------------------------------------------------------------
package rwsp_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SPEED_W  = 16;
  localparam int TIME_W   = 32;
  localparam int PWM_W    = 11;
  localparam int SCALE_W  = 10;
  localparam int THR_W    = 15;
  localparam int GAIN_W   = 16;
  localparam int PWMMAG_W = 10;
  localparam int PERIOD_W = 16;

  localparam int S_TDATA_W = 160;
  localparam int M_TDATA_W = 56;
  localparam int M_PAD_W   = M_TDATA_W - 2 * PWM_W - TIME_W;

  localparam int DT_W    = 31;
  localparam int REF_W   = 17;
  localparam int ERR_W   = 19;
  localparam int EMAG_W  = 18;
  localparam int INTEG_W = 24;
  localparam int QMAG_W  = 24;
  localparam int SUM_W   = 26;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 62;
  localparam int ACC_W   = 46;
  localparam int PMAG_W  = 18;
  localparam int PC_W    = 4;

  localparam int REF_SHIFT     = 8;
  localparam int INTEG_LIMIT   = 2 ** 21;
  localparam int EDT_SAT_BITS  = 23;
  localparam int RECIP_PRE     = 7;
  localparam int RECIP_SHIFT   = 37;
  localparam int RECIP_W       = 31;
  localparam int ACC_SHIFT     = 10;
  localparam int ROUND_SHIFT   = 28;

  // ceil(2^37 / 125): exact floor division by 125 for dividends below 2^30.
  localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

  localparam logic [SCALE_W-1:0]    RST_SPEED_SCALE  = 10'd256;
  localparam logic [THR_W-1:0]      RST_STOP_THR     = '0;
  localparam logic [GAIN_W-1:0]     RST_PROP_GAIN    = '0;
  localparam logic [GAIN_W-1:0]     RST_INTEG_GAIN   = '0;
  localparam logic [PWMMAG_W-1:0]   RST_MIN_MOVE     = '0;
  localparam logic [PWMMAG_W-1:0]   RST_MAX_PWM      = 10'd255;
  localparam logic [PERIOD_W-1:0]   RST_PERIOD       = 16'd20;
  localparam logic [TIME_W-1:0]     RST_MAX_RETURN   = 32'd30000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SPEED_SCALE,
    CFG_STOP_THRESHOLD,
    CFG_PROP_GAIN,
    CFG_INTEGRAL_GAIN,
    CFG_MIN_MOVE_PWM,
    CFG_MAX_PWM,
    CFG_DEFAULT_PERIOD,
    CFG_MAX_RETURN
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_REF,
    MUL_EDT,
    MUL_RECIP,
    MUL_PROP,
    MUL_INTG
  } mul_sel_e;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_CHECK,
    ALU_REF,
    ALU_SATCHK,
    ALU_INTEG,
    ALU_ACC_LOAD,
    ALU_ACC_ADD,
    ALU_ROUND,
    ALU_PWM,
    ALU_OUT
  } alu_op_e;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_ITEM,
    JC_STOP,
    JC_NO_INTEG,
    JC_FIRST_WHEEL,
    JC_OUT_FREE
  } jmp_cond_e;

  typedef struct packed {
    mul_sel_e            mul;
    alu_op_e             alu;
    jmp_cond_e           cond;
    logic [PC_W-1:0]     target;
  } ctrl_t;

  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
  localparam logic [PC_W-1:0] STEP_WHEEL = 4'd2;
  localparam logic [PC_W-1:0] STEP_REF   = 4'd3;
  localparam logic [PC_W-1:0] STEP_EDT   = 4'd4;
  localparam logic [PC_W-1:0] STEP_RECIP = 4'd5;
  localparam logic [PC_W-1:0] STEP_INTEG = 4'd6;
  localparam logic [PC_W-1:0] STEP_PROP  = 4'd7;
  localparam logic [PC_W-1:0] STEP_INTG  = 4'd8;
  localparam logic [PC_W-1:0] STEP_ADD   = 4'd9;
  localparam logic [PC_W-1:0] STEP_ROUND = 4'd10;
  localparam logic [PC_W-1:0] STEP_PWM   = 4'd11;
  localparam logic [PC_W-1:0] STEP_OUT   = 4'd12;
  localparam logic [PC_W-1:0] STEP_HOLD  = 4'd13;

  // Control store: one word per step, the wheel steps run once per wheel.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{mul: MUL_NONE, alu: ALU_NOP, cond: JC_NEVER, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.cond = JC_NO_ITEM;
        w.target = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.alu = ALU_CHECK;
        w.cond = JC_STOP;
        w.target = STEP_OUT;
      end
      STEP_WHEEL: w.mul = MUL_REF;
      STEP_REF: begin
        w.alu = ALU_REF;
        w.cond = JC_NO_INTEG;
        w.target = STEP_PROP;
      end
      STEP_EDT: w.mul = MUL_EDT;
      STEP_RECIP: begin
        w.mul = MUL_RECIP;
        w.alu = ALU_SATCHK;
      end
      STEP_INTEG: w.alu = ALU_INTEG;
      STEP_PROP: w.mul = MUL_PROP;
      STEP_INTG: begin
        w.mul = MUL_INTG;
        w.alu = ALU_ACC_LOAD;
      end
      STEP_ADD: w.alu = ALU_ACC_ADD;
      STEP_ROUND: w.alu = ALU_ROUND;
      STEP_PWM: begin
        w.alu = ALU_PWM;
        w.cond = JC_FIRST_WHEEL;
        w.target = STEP_WHEEL;
      end
      STEP_OUT: begin
        w.alu = ALU_OUT;
        w.cond = JC_OUT_FREE;
        w.target = STEP_IDLE;
      end
      STEP_HOLD: begin
        w.cond = JC_ALWAYS;
        w.target = STEP_OUT;
      end
      default: begin
        w.cond = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/replay_wheel_speed_pi.sv @@
// ----------------------------------------------------------------------------
// replay_wheel_speed_pi
// Dual PI wheel speed controller that replays a logged drive, one step per
// input transfer. The slave stream carries logged and measured wheel speeds,
// two timestamps, the elapsed return time and the end-of-log mark on tlast.
// Each input transfer yields exactly one master transfer with both PWM
// commands and the wait time; tlast marks a finished replay.
// A microcoded sequencer with one shared 33x33 multiplier does the work. It
// runs the wheel steps once per wheel; with a zero integral gain it skips the
// integrator update, and once finished it goes straight to the output step.
// The result is loaded into the output register, and the next input is taken
// in the cycle after that when the receiver keeps up.
// If the receiver stalls, the sequencer holds its finished step until the
// output register frees up. Reset clears the integrators, the finish flag
// and the registers to their defaults. The user must write registers over
// the plain write port only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module replay_wheel_speed_pi
  import rwsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // logged_speed_left, logged_speed_right, time_this_sample,
  // time_prior_sample, measured_speed_left, measured_speed_right, elapsed_ms
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pwm_left, pwm_right, wait_ms, zero padding
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam logic signed [SUM_W-1:0]   SUM_HI   = SUM_W'(INTEG_LIMIT);
  localparam logic signed [SUM_W-1:0]   SUM_LO   = -SUM_HI;
  localparam logic signed [INTEG_W-1:0] INTEG_HI = INTEG_W'(INTEG_LIMIT);
  localparam logic signed [INTEG_W-1:0] INTEG_LO = -INTEG_HI;
  localparam logic [QMAG_W-1:0]         QMAG_SAT = QMAG_W'(1) << EDT_SAT_BITS;
  localparam logic [ACC_W-1:0]          RND_POS  = ACC_W'(1) << (ROUND_SHIFT - 1);
  localparam logic [ACC_W-1:0]          RND_NEG  = RND_POS + ACC_W'(1);

  logic [SCALE_W-1:0]  speed_scale_q;
  logic [THR_W-1:0]    stop_thr_q;
  logic [GAIN_W-1:0]   prop_gain_q;
  logic [GAIN_W-1:0]   integ_gain_q;
  logic [PWMMAG_W-1:0] min_move_q;
  logic [PWMMAG_W-1:0] max_pwm_q;
  logic [PERIOD_W-1:0] period_q;
  logic [TIME_W-1:0]   max_return_q;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  logic            take_jump;

  logic signed [SPEED_W-1:0] logged_l_q, logged_r_q, meas_l_q, meas_r_q;
  logic [TIME_W-1:0]         this_q, prior_q, elapsed_q;
  logic                      eol_q;

  logic                      w_q, w_d;
  logic                      done_q, done_d;
  logic                      fin_q, fin_d;
  logic signed [INTEG_W-1:0] integ_l_q, integ_l_d, integ_r_q, integ_r_d;
  logic [DT_W-1:0]           dt_q, dt_d;
  logic [REF_W-1:0]          ref_q, ref_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic                      sat_q, sat_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [PMAG_W-1:0]         pmag_q, pmag_d;
  logic                      pneg_q, pneg_d;
  logic signed [PWM_W-1:0]   pwm_l_q, pwm_l_d, pwm_r_q, pwm_r_d;

  logic                      out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0]      out_data_q, out_data_d;
  logic                      out_last_q, out_last_d;

  logic                      in_fire, out_free, load_out, stop;
  logic                      integ_ok;
  logic signed [SPEED_W-1:0] logged_w, meas_w;
  logic signed [INTEG_W-1:0] integ_w;
  logic [SPEED_W-1:0]        log_mag;
  logic [EMAG_W-1:0]         err_mag;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;

  logic [TIME_W-1:0]         diff;
  logic [REF_W-1:0]          ref_raw, ref_v;
  logic [QMAG_W-1:0]         qmag;
  logic signed [SUM_W-1:0]   qext, sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic [ACC_W-1:0]          acc_base, rnd;
  logic                      pwm_neg;
  logic [PMAG_W-1:0]         mag;
  logic signed [PWM_W-1:0]   pwm_val;

  assign ctrl          = ucode(pc_q);
  assign s_axis_tready = (pc_q == STEP_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load_out      = (ctrl.alu == ALU_OUT) && out_free;
  assign stop          = done_q || (elapsed_q > max_return_q) || eol_q;
  assign integ_ok      = (integ_l_q <= INTEG_HI) && (integ_l_q >= INTEG_LO) &&
                         (integ_r_q <= INTEG_HI) && (integ_r_q >= INTEG_LO);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign logged_w = w_q ? logged_r_q : logged_l_q;
  assign meas_w   = w_q ? meas_r_q : meas_l_q;
  assign integ_w  = w_q ? integ_r_q : integ_l_q;
  assign log_mag  = logged_w[SPEED_W-1] ? SPEED_W'(-logged_w) : SPEED_W'(logged_w);
  assign err_mag  = err_q[ERR_W-1] ? EMAG_W'(-err_q) : EMAG_W'(err_q);

  // Sequencer.
  always_comb begin
    case (ctrl.cond)
      JC_NEVER:       take_jump = 1'b0;
      JC_ALWAYS:      take_jump = 1'b1;
      JC_NO_ITEM:     take_jump = !in_fire;
      JC_STOP:        take_jump = stop;
      JC_NO_INTEG:    take_jump = (integ_gain_q == '0);
      JC_FIRST_WHEEL: take_jump = !w_q;
      JC_OUT_FREE:    take_jump = out_free;
      default:        take_jump = 1'b1;
    endcase
    pc_d = take_jump ? ctrl.target : PC_W'(pc_q + 1'b1);
  end

  // Shared multiplier, operands chosen by the control word.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_REF: begin
        mul_a = MUL_W'(log_mag);
        mul_b = MUL_W'(speed_scale_q);
      end
      MUL_EDT: begin
        mul_a = MUL_W'(err_mag);
        mul_b = MUL_W'(dt_q);
      end
      MUL_RECIP: begin
        mul_a = MUL_W'({prod_q[EDT_SAT_BITS-1:0], {RECIP_PRE{1'b0}}});
        mul_b = MUL_W'(RECIP_125);
      end
      MUL_PROP: begin
        mul_a = MUL_W'(err_q);
        mul_b = MUL_W'(prop_gain_q);
      end
      MUL_INTG: begin
        mul_a = MUL_W'(integ_w);
        mul_b = MUL_W'(integ_gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // Datapath.
  always_comb begin
    w_d         = w_q;
    done_d      = done_q;
    fin_d       = fin_q;
    integ_l_d   = integ_l_q;
    integ_r_d   = integ_r_q;
    dt_d        = dt_q;
    ref_d       = ref_q;
    err_d       = err_q;
    sat_d       = sat_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    pmag_d      = pmag_q;
    pneg_d      = pneg_q;
    pwm_l_d     = pwm_l_q;
    pwm_r_d     = pwm_r_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    diff      = this_q - prior_q;
    ref_raw   = prod_q[REF_W+REF_SHIFT-1:REF_SHIFT];
    ref_v     = (ref_raw < REF_W'(stop_thr_q)) ? '0 : ref_raw;
    qmag      = sat_q ? QMAG_SAT : prod_q[RECIP_SHIFT+QMAG_W-1:RECIP_SHIFT];
    qext      = $signed({{(SUM_W-QMAG_W){1'b0}}, qmag});
    sum       = SUM_W'(integ_w) + (err_q[ERR_W-1] ? -qext : qext);
    integ_new = (sum > SUM_HI) ? INTEG_HI : ((sum < SUM_LO) ? INTEG_LO : INTEG_W'(sum));
    acc_base  = acc_q[ACC_W-1] ? ~acc_q : acc_q;
    rnd       = acc_base + (acc_q[ACC_W-1] ? RND_NEG : RND_POS);
    pwm_neg   = pneg_q && (pmag_q != '0);
    mag       = pmag_q;
    if ((ref_q != '0) && (mag < PMAG_W'(min_move_q))) begin
      mag = PMAG_W'(min_move_q);
    end
    if (mag > PMAG_W'(max_pwm_q)) begin
      mag = PMAG_W'(max_pwm_q);
    end
    pwm_val = pwm_neg ? -PWM_W'(mag) : PWM_W'(mag);

    if (ctrl.mul != MUL_NONE) begin
      prod_d = mul_full[PROD_W-1:0];
    end

    if (in_fire) begin
      w_d = 1'b0;
    end

    case (ctrl.alu)
      ALU_NOP: ;
      ALU_CHECK: begin
        dt_d  = ((diff == '0) || diff[TIME_W-1]) ? DT_W'(period_q) : diff[DT_W-1:0];
        fin_d = 1'b0;
        if (stop) begin
          done_d  = 1'b1;
          fin_d   = 1'b1;
          dt_d    = '0;
          pwm_l_d = '0;
          pwm_r_d = '0;
        end
      end
      ALU_REF: begin
        ref_d = ref_v;
        err_d = $signed({{(ERR_W-REF_W){1'b0}}, ref_v}) - ERR_W'(meas_w);
      end
      ALU_SATCHK: sat_d = |prod_q[PROD_W-1:EDT_SAT_BITS];
      ALU_INTEG: begin
        if (w_q) begin
          integ_r_d = integ_new;
        end else begin
          integ_l_d = integ_new;
        end
      end
      ALU_ACC_LOAD: acc_d = ACC_W'(prod_q) <<< ACC_SHIFT;
      ALU_ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      ALU_ROUND: begin
        pmag_d = rnd[ROUND_SHIFT+PMAG_W-1:ROUND_SHIFT];
        pneg_d = acc_q[ACC_W-1];
      end
      ALU_PWM: begin
        if (w_q) begin
          pwm_r_d = pwm_val;
        end else begin
          pwm_l_d = pwm_val;
        end
        w_d = !w_q;
      end
      ALU_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {{M_PAD_W{1'b0}}, TIME_W'(dt_q), pwm_r_q, pwm_l_q};
          out_last_d  = fin_q;
        end
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_scale_q <= RST_SPEED_SCALE;
      stop_thr_q    <= RST_STOP_THR;
      prop_gain_q   <= RST_PROP_GAIN;
      integ_gain_q  <= RST_INTEG_GAIN;
      min_move_q    <= RST_MIN_MOVE;
      max_pwm_q     <= RST_MAX_PWM;
      period_q      <= RST_PERIOD;
      max_return_q  <= RST_MAX_RETURN;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_SPEED_SCALE:    speed_scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_STOP_THRESHOLD: stop_thr_q    <= cfg_data_i[THR_W-1:0];
        CFG_PROP_GAIN:      prop_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN:  integ_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_MIN_MOVE_PWM:   min_move_q    <= cfg_data_i[PWMMAG_W-1:0];
        CFG_MAX_PWM:        max_pwm_q     <= cfg_data_i[PWMMAG_W-1:0];
        CFG_DEFAULT_PERIOD: period_q      <= cfg_data_i[PERIOD_W-1:0];
        CFG_MAX_RETURN:     max_return_q  <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      w_q         <= 1'b0;
      done_q      <= 1'b0;
      integ_l_q   <= '0;
      integ_r_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      w_q         <= w_d;
      done_q      <= done_d;
      integ_l_q   <= integ_l_d;
      integ_r_q   <= integ_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      logged_l_q <= s_axis_tdata[15:0];
      logged_r_q <= s_axis_tdata[31:16];
      this_q     <= s_axis_tdata[63:32];
      prior_q    <= s_axis_tdata[95:64];
      meas_l_q   <= s_axis_tdata[111:96];
      meas_r_q   <= s_axis_tdata[127:112];
      elapsed_q  <= s_axis_tdata[159:128];
      eol_q      <= s_axis_tlast;
    end
    fin_q      <= fin_d;
    dt_q       <= dt_d;
    ref_q      <= ref_d;
    err_q      <= err_d;
    sat_q      <= sat_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    pmag_q     <= pmag_d;
    pneg_q     <= pneg_d;
    pwm_l_q    <= pwm_l_d;
    pwm_r_q    <= pwm_r_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  `RWSP_ASSERT_IMPL(a_done_sticky, $past(done_q), done_q, "finish flag dropped")
  `RWSP_ASSERT(a_integ_range, integ_ok, "integrator outside its clamp")
  `RWSP_ASSERT_IMPL(a_no_overwrite, load_out, out_free, "stalled result overwritten")
  `RWSP_ASSERT_IMPL(a_finished_zero, out_valid_q && out_last_q, out_data_q == '0, "finish data")

endmodule
